[design/fda_pkg.sv]
// ----------------------------------------------------------------------------
// fda_pkg
// Shared constants for the fractional delay line: default sizes, register
// map, output queue dimensions and remainder unit settings.
// ----------------------------------------------------------------------------
package fda_pkg;

	// default sizes
	localparam int STORE_DEPTH_DEF   = 65536;
	localparam int SAMPLE_BITS_DEF   = 24;
	localparam int FRACTION_BITS_DEF = 16;

	// register map
	localparam int APB_DATA_BITS    = 32;
	localparam int APB_ADDR_BITS    = 3;
	localparam int DELAY_WHOLE_BITS = 16;
	localparam logic REG_DELAY_WHOLE    = 1'b0;
	localparam logic REG_DELAY_FRACTION = 1'b1;

	// output queue
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_AW    = 2;
	localparam int OUTQ_CW    = 3;

	// remainder unit: reciprocal multiply, then multiply back and subtract
	localparam int REM_CW    = 2;
	localparam int REM_STEPS = 2;

endpackage

[design/fda_store.sv]
// ----------------------------------------------------------------------------
// fda_store
// Sample store: one write port and two registered read ports, read-first.
// A fill count marks which entries were written since reset; an entry not
// yet written reads as zero.
// ----------------------------------------------------------------------------
module fda_store
	import fda_pkg::*;
#(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int AW = $clog2(STORE_DEPTH),
	localparam int FW = $clog2(STORE_DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          access,
	input  logic [AW-1:0]                 wr_addr,
	input  logic signed [SAMPLE_BITS-1:0] wr_data,
	input  logic [AW-1:0]                 rd_addr_a,
	input  logic [AW-1:0]                 rd_addr_b,
	output logic signed [SAMPLE_BITS-1:0] rd_data_a,
	output logic signed [SAMPLE_BITS-1:0] rd_data_b
);

	localparam logic [FW-1:0] FILL_FULL = FW'(STORE_DEPTH);

	logic signed [SAMPLE_BITS-1:0] mem [STORE_DEPTH];
	logic signed [SAMPLE_BITS-1:0] rd_a_q;
	logic signed [SAMPLE_BITS-1:0] rd_b_q;
	logic                          ok_a_q;
	logic                          ok_b_q;
	logic [FW-1:0]                 fill_q;

	// storage array, reads see the contents before this beat's write
	always_ff @(posedge clk) begin
		if (access) begin
			mem[wr_addr] <= wr_data;
			rd_a_q       <= mem[rd_addr_a];
			rd_b_q       <= mem[rd_addr_b];
		end
	end

	// fill count, entries are written in index order from zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ok_a_q <= 1'b0;
			ok_b_q <= 1'b0;
		end else if (access) begin
			ok_a_q <= {{(FW-AW){1'b0}}, rd_addr_a} < fill_q;
			ok_b_q <= {{(FW-AW){1'b0}}, rd_addr_b} < fill_q;
			if (fill_q != FILL_FULL) begin
				fill_q <= fill_q + FW'(1);
			end
		end
	end

	// unwritten entries read as zero
	assign rd_data_a = ok_a_q ? rd_a_q : '0;
	assign rd_data_b = ok_b_q ? rd_b_q : '0;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_FULL)
		else $error("fill count beyond store depth");

	a_fill_grows: assert property (@(posedge clk) disable iff (!arst_n)
		access |=> fill_q != '0)
		else $error("write left fill count at zero");

endmodule

[design/fractional_delay_allpass_top.sv]
// ----------------------------------------------------------------------------
// fractional_delay_allpass_top
// Circular delay line with whole and fractional delay, first-order allpass
// interpolation and saturation of the result to the sample width.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel: in_valid / in_stall carry one sample_in per beat
//  - output channel: out_valid / out_stall carry one sample_out per input beat
//  - delay_whole at 0x0, delay_fraction at 0x4 on the APB port; write them
//    only while no beat is in flight
//  - out_valid rises once a result has passed the store read, the product
//    and sum registers and entered the output queue
//  - beats never enter back to back, as the allpass feedback through the
//    previous output (multiply, then subtract, round and saturate) needs it
//  - after a write to delay_whole the input stalls while the
//    delay is reduced modulo the store depth by a reciprocal multiply
//  - a four-entry output queue lets the input run on while the receiver
//    stalls; the input stalls once four results are owed
//  - reset clears the registers, the write index and the previous output;
//    the store needs no clearing pass, a fill count makes unwritten entries
//    read as zero
// ----------------------------------------------------------------------------
module fractional_delay_allpass_top
	import fda_pkg::*;
#(
	parameter int STORE_DEPTH   = STORE_DEPTH_DEF,
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [APB_ADDR_BITS-1:0]      paddr,
	input  logic [APB_DATA_BITS-1:0]      pwdata,
	output logic [APB_DATA_BITS-1:0]      prdata,
	output logic                          pready
);

	localparam int SB  = SAMPLE_BITS;
	localparam int FB  = FRACTION_BITS;
	localparam int AW  = $clog2(STORE_DEPTH);
	localparam int PW  = SB + FB + 2;
	localparam int MW  = PW + 1;
	localparam int ACW = PW + 2;
	localparam int RPW = DELAY_WHOLE_BITS + 32;

	localparam logic [AW:0]   DEPTH_C  = (AW+1)'(STORE_DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(STORE_DEPTH - 1);
	localparam logic signed [ACW-1:0] HALF_C = ACW'(64'd1 << (FB - 1));
	localparam logic signed [ACW-1:0] SMAX_C = {{(ACW-SB+1){1'b0}}, {(SB-1){1'b1}}};
	localparam logic signed [ACW-1:0] SMIN_C = {{(ACW-SB+1){1'b1}}, {(SB-1){1'b0}}};
	// ceil(2^32 / depth) gives an exact quotient for 16-bit delays; a store
	// deeper than any delay needs no reduction at all
	localparam logic [31:0] RECIP_C =
		(64'(STORE_DEPTH) > (64'd1 << DELAY_WHOLE_BITS)) ? 32'd0 :
		32'(((64'd1 << 32) + 64'(STORE_DEPTH) - 64'd1) / 64'(STORE_DEPTH));
	localparam logic [31:0] DEPTH_W = 32'(STORE_DEPTH);

	// configuration state
	logic [DELAY_WHOLE_BITS-1:0] delay_whole_q;
	logic [FB-1:0]               delay_fraction_q;
	logic [AW-1:0]               back_q;
	logic [DELAY_WHOLE_BITS-1:0] quot_q;
	logic [REM_CW-1:0]           rem_cnt_q;
	logic                        cfg_wr;
	logic                        busy;
	logic [RPW-1:0]              recip_prod;
	logic [31:0]                 quot_depth;
	logic [DELAY_WHOLE_BITS-1:0] rem_val;

	// datapath state
	logic [AW-1:0]               widx_q;
	logic signed [SB-1:0]        prev_q;
	logic                        vld_s1;
	logic                        vld_s2;
	logic                        vld_s3;
	logic signed [PW-1:0]        prod_a_s2;
	logic signed [PW-1:0]        prod_b_s2;
	logic signed [MW-1:0]        sum_s3;
	logic signed [PW-1:0]        prod_p_s3;

	// output queue
	logic signed [SB-1:0]        oq_mem [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0]          oq_wr_q;
	logic [OUTQ_AW-1:0]          oq_rd_q;
	logic [OUTQ_CW-1:0]          oq_cnt_q;
	logic [OUTQ_CW-1:0]          owed_q;

	logic                        in_beat;
	logic                        out_beat;
	logic [FB:0]                 omd;
	logic [AW:0]                 rd_diff;
	logic [AW-1:0]               rd_idx;
	logic [AW-1:0]               rd_idx1;
	logic signed [SB-1:0]        rd_a;
	logic signed [SB-1:0]        rd_b;
	logic signed [ACW-1:0]       acc;
	logic signed [ACW-1:0]       acc_sh;
	logic signed [SB-1:0]        y_sat;

	// ------------------------------------------------------------------
	// configuration port
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[2])
			REG_DELAY_WHOLE:    prdata = APB_DATA_BITS'(delay_whole_q);
			REG_DELAY_FRACTION: prdata = APB_DATA_BITS'(delay_fraction_q);
			default:            prdata = '0;
		endcase
	end

	// delay_whole modulo the store depth: quotient by reciprocal, then subtract
	assign recip_prod = RPW'(delay_whole_q) * RPW'(RECIP_C);
	assign quot_depth = 32'(quot_q) * DEPTH_W;
	assign rem_val    = delay_whole_q - quot_depth[DELAY_WHOLE_BITS-1:0];
	assign busy       = rem_cnt_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_whole_q    <= '0;
			delay_fraction_q <= '0;
			back_q           <= '0;
			quot_q           <= '0;
			rem_cnt_q        <= '0;
		end else if (cfg_wr && paddr[2] == REG_DELAY_WHOLE) begin
			delay_whole_q <= pwdata[DELAY_WHOLE_BITS-1:0];
			rem_cnt_q     <= REM_CW'(REM_STEPS);
		end else begin
			if (cfg_wr && paddr[2] == REG_DELAY_FRACTION) begin
				delay_fraction_q <= pwdata[FB-1:0];
			end
			if (busy) begin
				rem_cnt_q <= rem_cnt_q - REM_CW'(1);
				if (rem_cnt_q == REM_CW'(REM_STEPS)) begin
					quot_q <= recip_prod[RPW-1:32];
				end else begin
					back_q <= AW'(rem_val);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// input handshake and read addresses
	// ------------------------------------------------------------------
	assign in_stall = busy || (owed_q == OUTQ_CW'(OUTQ_DEPTH)) || vld_s1;
	assign in_beat  = in_valid && !in_stall;
	assign out_beat = out_valid && !out_stall;

	assign rd_diff = {1'b0, widx_q} - {1'b0, back_q};
	assign rd_idx  = rd_diff[AW] ? AW'(rd_diff + DEPTH_C) : rd_diff[AW-1:0];
	assign rd_idx1 = (rd_idx == LAST_IDX) ? '0 : rd_idx + AW'(1);

	assign omd = {1'b1, {FB{1'b0}}} - {1'b0, delay_fraction_q};

	fda_store #(
		.STORE_DEPTH (STORE_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.access    (in_beat),
		.wr_addr   (widx_q),
		.wr_data   (sample_in),
		.rd_addr_a (rd_idx),
		.rd_addr_b (rd_idx1),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	// ------------------------------------------------------------------
	// interpolation pipeline
	// ------------------------------------------------------------------
	// feed-forward products, then their sum and the feedback product
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			prod_a_s2 <= PW'($signed({1'b0, omd}) * rd_a);
			prod_b_s2 <= PW'($signed({2'b00, delay_fraction_q}) * rd_b);
		end
		if (vld_s2) begin
			sum_s3    <= MW'(prod_a_s2) + MW'(prod_b_s2);
			prod_p_s3 <= PW'($signed({1'b0, omd}) * prev_q);
		end
	end

	// subtract feedback, round half up, saturate
	assign acc    = ACW'(sum_s3) - ACW'(prod_p_s3) + HALF_C;
	assign acc_sh = acc >>> FB;

	always_comb begin
		if (acc_sh > SMAX_C) begin
			y_sat = SMAX_C[SB-1:0];
		end else if (acc_sh < SMIN_C) begin
			y_sat = SMIN_C[SB-1:0];
		end else begin
			y_sat = acc_sh[SB-1:0];
		end
	end

	// stage valids, write index and feedback register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			widx_q <= '0;
			prev_q <= '0;
		end else begin
			vld_s1 <= in_beat;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			if (in_beat) begin
				widx_q <= (widx_q == LAST_IDX) ? '0 : widx_q + AW'(1);
			end
			if (vld_s3) begin
				prev_q <= y_sat;
			end
		end
	end

	// ------------------------------------------------------------------
	// output queue
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (vld_s3) begin
			oq_mem[oq_wr_q] <= y_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
			owed_q   <= '0;
		end else begin
			if (vld_s3) begin
				oq_wr_q <= oq_wr_q + OUTQ_AW'(1);
			end
			if (out_beat) begin
				oq_rd_q <= oq_rd_q + OUTQ_AW'(1);
			end
			oq_cnt_q <= oq_cnt_q + OUTQ_CW'(vld_s3) - OUTQ_CW'(out_beat);
			owed_q   <= owed_q + OUTQ_CW'(in_beat) - OUTQ_CW'(out_beat);
		end
	end

	assign out_valid  = oq_cnt_q != '0;
	assign sample_out = oq_mem[oq_rd_q];

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	a_owed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		owed_q <= OUTQ_CW'(OUTQ_DEPTH))
		else $error("more results owed than queue entries");

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> oq_cnt_q < OUTQ_CW'(OUTQ_DEPTH) || out_beat)
		else $error("result pushed into a full output queue");

	a_feedback_gap: assert property (@(posedge clk) disable iff (!arst_n)
		!(vld_s1 && vld_s2))
		else $error("beats too close for the feedback path");

	a_queue_le_owed: assert property (@(posedge clk) disable iff (!arst_n)
		oq_cnt_q <= owed_q)
		else $error("queue holds more than is owed");

endmodule

[bench/tb_fractional_delay_allpass_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fractional_delay_allpass_top
// Self-checking bench for the fractional delay line. A queue-fed driver
// offers samples with random gaps. A monitor applies random and long stalls
// and checks every output beat against an in-bench allpass interpolator.
// Delay registers are written over APB between bursts and read back.
// ----------------------------------------------------------------------------
module tb_fractional_delay_allpass_top;
	import fda_pkg::*;

	typedef logic signed [SAMPLE_BITS_DEF-1:0] audio_t;

	localparam int     DEPTH       = STORE_DEPTH_DEF;
	localparam longint FRAC_ONE    = longint'(1) << FRACTION_BITS_DEF;
	localparam audio_t SAMPLE_MAX  = {1'b0, {(SAMPLE_BITS_DEF-1){1'b1}}};
	localparam audio_t SAMPLE_MIN  = {1'b1, {(SAMPLE_BITS_DEF-1){1'b0}}};
	localparam int     HOLD_CYCLES = 80;
	localparam int     TARGET_BEATS = 1725;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     in_valid  = 1'b0;
	logic                     in_stall;
	audio_t                   sample_in = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	audio_t                   sample_out;
	logic                     psel      = 1'b0;
	logic                     penable   = 1'b0;
	logic                     pwrite    = 1'b0;
	logic [APB_ADDR_BITS-1:0] paddr     = '0;
	logic [APB_DATA_BITS-1:0] pwdata    = '0;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	fractional_delay_allpass_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample_in (sample_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sample_out(sample_out),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// interpolator state mirrored in the bench
	audio_t          delay_mem [DEPTH] = '{default: '0};
	int unsigned     wr_ptr   = 0;
	audio_t          prev_out = '0;
	int unsigned     whole_q  = 0;
	logic [15:0]     frac_q   = '0;

	audio_t          pending [$];
	audio_t          owed_out [$];
	int unsigned     mismatches    = 0;
	int unsigned     beats_in      = 0;
	int unsigned     beats_out     = 0;
	int unsigned     hold_requests = 0;
	int unsigned     holds_served  = 0;
	int unsigned     gap_left      = 0;
	int unsigned     stall_left    = 0;
	int unsigned     hold_left     = 0;
	logic            send_gaps     = 1'b0;
	logic            recv_stalls   = 1'b0;

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// one step of the delay line: read two taps, interpolate, saturate, write
	function automatic audio_t allpass_predict(audio_t fresh);
		int unsigned rd_a;
		int unsigned rd_b;
		longint      tap_a;
		longint      tap_b;
		longint      frac;
		longint      keep;
		longint      acc;
		longint      y;
		rd_a  = (wr_ptr + DEPTH - (whole_q % DEPTH)) % DEPTH;
		rd_b  = (rd_a + 1) % DEPTH;
		tap_a = delay_mem[rd_a];
		tap_b = delay_mem[rd_b];
		frac  = frac_q;
		keep  = FRAC_ONE - frac;
		acc   = keep * tap_a + frac * tap_b - keep * longint'(prev_out);
		y     = (acc + (FRAC_ONE >>> 1)) >>> FRACTION_BITS_DEF;
		if (y > longint'(SAMPLE_MAX))
			y = SAMPLE_MAX;
		if (y < longint'(SAMPLE_MIN))
			y = SAMPLE_MIN;
		prev_out         = audio_t'(y);
		delay_mem[wr_ptr] = fresh;
		wr_ptr           = (wr_ptr + 1) % DEPTH;
		return prev_out;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return 0;
		if (roll < 80)
			return $urandom_range(1, 3);
		if (roll < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	function automatic audio_t pick_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2, 3: return audio_t'(int'($urandom_range(0, 64)) - 32);
			default: return audio_t'($urandom());
		endcase
	endfunction

	function automatic logic [APB_ADDR_BITS-1:0] reg_addr(logic idx);
		return {idx, 2'b00};
	endfunction

	task automatic note_mismatch(string what, longint want, longint got);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	// input driver: one beat at a time from the pending queue
	always @(posedge clk) begin : drive_p
		logic   taken;
		logic   next_valid;
		audio_t next_sample;
		taken       = in_valid && !in_stall;
		next_valid  = in_valid && !taken;
		next_sample = sample_in;
		if (taken) begin
			owed_out.push_back(allpass_predict(sample_in));
			beats_in++;
			gap_left = send_gaps ? pick_gap() : 0;
		end
		if (!arst_n) begin
			next_valid = 1'b0;
		end else if (!next_valid) begin
			if (gap_left != 0) begin
				gap_left--;
			end else if (pending.size() != 0) begin
				next_valid  = 1'b1;
				next_sample = pending.pop_front();
			end
		end
		in_valid  <= next_valid;
		sample_in <= next_sample;
	end

	// output monitor: compare each beat, then pick the next stall
	always @(posedge clk) begin : watch_p
		audio_t want;
		logic   next_stall;
		if (out_valid === 1'b1 && !out_stall) begin
			beats_out++;
			if (owed_out.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] output beat %0d with nothing owed", $realtime, sample_out);
			end else begin
				want = owed_out.pop_front();
				if (sample_out !== want)
					note_mismatch("sample_out", want, sample_out);
			end
		end
		if (holds_served != hold_requests) begin
			holds_served++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			next_stall = 1'b1;
		end else if (stall_left != 0) begin
			stall_left--;
			next_stall = 1'b1;
		end else begin
			next_stall = 1'b0;
			if (recv_stalls && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
		out_stall <= next_stall;
	end

	// nothing queued, nothing on the wire, nothing owed
	task automatic wait_idle();
		do @(negedge clk);
		while (pending.size() != 0 || in_valid || owed_out.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_write(logic idx, logic [APB_DATA_BITS-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= reg_addr(idx);
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_reg(logic idx, logic [APB_DATA_BITS-1:0] want);
		logic [APB_DATA_BITS-1:0] got;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= reg_addr(idx);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== want)
			note_mismatch(idx == REG_DELAY_WHOLE ? "delay_whole readback" :
				"delay_fraction readback", want, got);
	endtask

	// set both delays (upper data bits are junk), read back, then queue a burst
	task automatic run_phase(int unsigned whole, int unsigned frac, audio_t items[$],
			logic hold);
		wait_idle();
		apb_write(REG_DELAY_WHOLE, {16'($urandom), 16'(whole)});
		whole_q = whole & 32'hFFFF;
		apb_write(REG_DELAY_FRACTION, {16'($urandom), 16'(frac)});
		frac_q = 16'(frac);
		check_reg(REG_DELAY_WHOLE, {16'b0, 16'(whole)});
		check_reg(REG_DELAY_FRACTION, {16'b0, 16'(frac)});
		@(negedge clk);
		if (hold)
			hold_requests++;
		foreach (items[i])
			pending.push_back(items[i]);
	endtask

	// stimulus sequence
	initial begin : stim_p
		audio_t      items [$];
		int unsigned whole;
		int unsigned frac;
		int unsigned count;
		int unsigned offered;
		int unsigned phases;
		offered = 0;
		phases  = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		check_reg(REG_DELAY_WHOLE, '0);
		check_reg(REG_DELAY_FRACTION, '0);

		// directed: reset delays, extremes and bit patterns
		items = '{SAMPLE_MAX, SAMPLE_MIN, audio_t'(0), audio_t'(-1), audio_t'(1),
			audio_t'(24'h555555), audio_t'(24'hAAAAAA)};
		run_phase(0, 0, items, 1'b0);
		// one sample back, no fraction: swings drive the output into saturation
		items = '{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX};
		run_phase(1, 0, items, 1'b0);
		// largest whole delay and fraction: read wraps to one ahead of the write
		items = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, audio_t'(0)};
		run_phase(65535, 65535, items, 1'b0);
		// half fraction with odd sums lands on rounding ties
		items = '{audio_t'(1), audio_t'(-1), audio_t'(3), audio_t'(-3), SAMPLE_MAX};
		run_phase(2, 32768, items, 1'b0);
		// zero whole delay with the smallest fraction
		items = '{SAMPLE_MIN, audio_t'(7), SAMPLE_MAX};
		run_phase(0, 1, items, 1'b0);
		offered = 25;
		phases  = 5;

		// back-pressure: long receiver hold while the sender streams flat out
		send_gaps   = 1'b0;
		recv_stalls = 1'b0;
		items.delete();
		repeat (60) items.push_back(pick_sample());
		run_phase(5, 20000, items, 1'b1);
		// sender waits for every owed result before going on
		wait_idle();
		repeat (40) pending.push_back(pick_sample());
		offered += 100;
		phases++;

		// random bursts over many delay settings
		while (offered < TARGET_BEATS) begin
			case ($urandom_range(0, 7))
				0: whole = 0;
				1: whole = 1;
				2: whole = 65535;
				3: whole = 65534;
				4, 5: whole = $urandom_range(0, 32);
				default: whole = $urandom_range(0, 65535);
			endcase
			case ($urandom_range(0, 7))
				0: frac = 0;
				1: frac = 65535;
				2: frac = 32768;
				3: frac = 1;
				default: frac = $urandom_range(0, 65535);
			endcase
			count = $urandom_range(40, 160);
			items.delete();
			repeat (count) items.push_back(pick_sample());
			send_gaps   = $urandom_range(0, 3) != 0;
			recv_stalls = $urandom_range(0, 3) != 0;
			run_phase(whole, frac, items, $urandom_range(0, 9) == 0);
			offered += count;
			phases++;
		end

		// drain, then watch a little longer for stray beats
		wait_idle();
		repeat (20) @(negedge clk);
		$display("run covered %0d samples in %0d delay settings, %0d results checked",
			beats_in, phases, beats_out);
		$display("long receiver holds: %0d, mismatches: %0d", holds_served, mismatches);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// watchdog
	initial begin
		#4_000_000;
		$display("timeout: %0d results still owed", owed_out.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
